[rtl/rmp_pkg.sv]
// Shared types and constants for the ray-march photoionisation unit.
// No dependencies; imported by every module of the block except rmp_checker.
package rmp_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_INITIAL_FLUX    = 2'd0;
  localparam logic [1:0] REG_ABSORB_SCALE    = 2'd1;
  localparam logic [1:0] REG_RATE_SCALE      = 2'd2;
  localparam logic [1:0] REG_CUTOFF_FRACTION = 2'd3;

  localparam logic [31:0] INITIAL_FLUX_RST    = 32'h0001_0000;
  localparam logic [31:0] ABSORB_SCALE_RST    = 32'h0001_0000;
  localparam logic [31:0] RATE_SCALE_RST      = 32'h0001_0000;
  localparam logic [15:0] CUTOFF_FRACTION_RST = 16'h0001;

  // tau limit 12.0 in Q16.16, reciprocal of 3 for x/3 = (x*R) >> 33
  localparam logic [47:0] TAU_LIMIT  = 48'(12) << 16;
  localparam logic [32:0] DIV3_RECIP = 33'h0_AAAA_AAAB;
  localparam logic [16:0] Q16_ONE    = 17'h1_0000;

  typedef struct packed {
    logic [31:0] initial_flux;
    logic [31:0] absorb_scale;
    logic [31:0] rate_scale;
    logic [15:0] cutoff_fraction;
  } rmp_cfg_t;

  // One cell handed from the flux march to the rate back end
  typedef struct packed {
    logic [31:0] absorbed;
    logic [31:0] density;
    logic [31:0] entering;
    logic [31:0] exit_flux;
    logic        last;
    logic        cut;
  } rmp_entry_t;

endpackage

[rtl/rmp_front.sv]
// Flux march front end: accepts cells, evaluates exp(-tau) on a shared multiplier,
// updates the running flux and cut flag, and pushes one entry per cell. Uses rmp_pkg.
module rmp_front import rmp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  rmp_cfg_t    cfg,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_density,
  input  logic        in_first_in_ray,
  input  logic        in_last_in_ray,
  input  logic        q_full,
  output logic        q_push,
  output rmp_entry_t  q_data
);

  localparam logic [3:0] F_IDLE = 4'd0;
  localparam logic [3:0] F_TAU  = 4'd1;
  localparam logic [3:0] F_YY   = 4'd2;
  localparam logic [3:0] F_T2   = 4'd3;
  localparam logic [3:0] F_T3   = 4'd4;
  localparam logic [3:0] F_T3D  = 4'd5;
  localparam logic [3:0] F_T4   = 4'd6;
  localparam logic [3:0] F_SQ   = 4'd7;
  localparam logic [3:0] F_SQW  = 4'd8;
  localparam logic [3:0] F_ABS  = 4'd9;
  localparam logic [3:0] F_NFL  = 4'd10;
  localparam logic [3:0] F_CUT  = 4'd11;
  localparam logic [3:0] F_CMP  = 4'd12;
  localparam logic [3:0] F_PUSH = 4'd13;

  logic [3:0]  state_r, state_nxt;
  logic [31:0] flux_r;
  logic        cut_r;
  logic [31:0] dens_r;
  logic        last_r;
  logic [65:0] p_r;
  logic [27:0] y_r;
  logic        big_r;
  logic [30:0] t2_r, t3_r;
  logic [32:0] s_r;
  logic [2:0]  cnt_r;
  logic [16:0] e_r;
  logic [31:0] absorbed_r, nflux_r;
  rmp_entry_t  ent_r;

  logic [32:0] mul_a, mul_b;
  logic [27:0] y_c;
  logic [33:0] s_sum;
  logic [65:0] sq_rnd, nf_rnd;
  logic [33:0] e_rnd;
  logic [16:0] e_c;
  logic        cut_now;

  assign in_stall = (state_r != F_IDLE);
  assign q_push   = (state_r == F_PUSH) && !q_full;
  assign q_data   = ent_r;

  assign y_c     = {p_r[35:16], 8'b0};
  assign s_sum   = (34'd1 << 32) - 34'(y_r) + 34'(t2_r) - 34'(t3_r) + 34'(p_r[63:34]);
  assign sq_rnd  = p_r + (66'd1 << 31);
  assign nf_rnd  = p_r + (66'd1 << 15);
  assign e_rnd   = 34'(s_r) + (34'd1 << 15);
  assign e_c     = big_r ? 17'd0 : e_rnd[32:16];
  assign cut_now = {nflux_r, 16'b0} < p_r[47:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      F_TAU: begin mul_a = 33'(dens_r);       mul_b = 33'(cfg.absorb_scale); end
      F_YY:  begin mul_a = 33'(y_c);          mul_b = 33'(y_c);              end
      F_T2:  begin mul_a = 33'(p_r[63:33]);   mul_b = 33'(y_r);              end
      F_T3:  begin mul_a = 33'(p_r[63:32]);   mul_b = DIV3_RECIP;            end
      F_T3D: begin mul_a = 33'(p_r[63:33]);   mul_b = 33'(y_r);              end
      F_SQ:  begin mul_a = s_r;               mul_b = s_r;                   end
      F_ABS: begin mul_a = 33'(flux_r);       mul_b = 33'(Q16_ONE - e_c);    end
      F_NFL: begin mul_a = 33'(flux_r);       mul_b = 33'(e_r);              end
      F_CUT: begin mul_a = 33'(cfg.cutoff_fraction); mul_b = 33'(cfg.initial_flux); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: if (in_valid) begin
        state_nxt = (cut_r && !in_first_in_ray) ? F_PUSH : F_TAU;
      end
      F_TAU:  state_nxt = F_YY;
      F_YY:   state_nxt = F_T2;
      F_T2:   state_nxt = F_T3;
      F_T3:   state_nxt = F_T3D;
      F_T3D:  state_nxt = F_T4;
      F_T4:   state_nxt = F_SQ;
      F_SQ:   state_nxt = F_SQW;
      F_SQW:  state_nxt = (cnt_r == 3'd7) ? F_ABS : F_SQ;
      F_ABS:  state_nxt = F_NFL;
      F_NFL:  state_nxt = F_CUT;
      F_CUT:  state_nxt = F_CMP;
      F_CMP:  state_nxt = F_PUSH;
      F_PUSH: if (!q_full) begin
        state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      flux_r  <= '0;
      cut_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == F_IDLE && in_valid && in_first_in_ray) begin
        flux_r <= cfg.initial_flux;
        cut_r  <= 1'b0;
      end
      if (state_r == F_CMP) begin
        flux_r <= nflux_r;
        cut_r  <= cut_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r <= 66'(mul_a) * 66'(mul_b);
    case (state_r)
      F_IDLE: if (in_valid) begin
        dens_r <= in_density;
        last_r <= in_last_in_ray;
        // cells beyond the cut carry zeros straight through
        ent_r  <= '{absorbed: 32'd0, density: 32'd0, entering: 32'd0,
                    exit_flux: 32'd0, last: in_last_in_ray, cut: 1'b1};
      end
      F_YY: begin
        y_r   <= y_c;
        big_r <= (p_r[63:16] >= TAU_LIMIT);
      end
      F_T2:  t2_r <= p_r[63:33];
      F_T3D: t3_r <= p_r[63:33];
      F_T4: begin
        s_r   <= s_sum[32:0];
        cnt_r <= '0;
      end
      F_SQW: begin
        s_r   <= sq_rnd[64:32];
        cnt_r <= cnt_r + 3'd1;
      end
      F_ABS: e_r <= e_c;
      F_NFL: absorbed_r <= p_r[47:16];
      F_CUT: nflux_r <= nf_rnd[47:16];
      F_CMP: begin
        ent_r <= '{absorbed: absorbed_r, density: dens_r, entering: flux_r,
                   exit_flux: (last_r && !cut_now) ? nflux_r : 32'd0,
                   last: last_r, cut: cut_now};
      end
      default: ;
    endcase
  end

endmodule

[rtl/rmp_queue.sv]
// Short register FIFO between the flux march and the rate back end.
// Uses rmp_pkg for the entry type.
module rmp_queue import rmp_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  rmp_entry_t push_data,
  output logic       full,
  input  logic       pop,
  output rmp_entry_t head,
  output logic       empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  rmp_entry_t    mem_r [DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_r];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= ptr_inc(wr_r);
      if (pop)  rd_r <= ptr_inc(rd_r);
      if (push && !pop) cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

endmodule

[rtl/rmp_back.sv]
// Rate back end: absorbed*rate_scale, saturation check and a bit-serial
// 64/32 divide by density, then the output register. Uses rmp_pkg.
module rmp_back import rmp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] rate_scale,
  input  logic        q_empty,
  input  rmp_entry_t  q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_rate_increment,
  output logic [31:0] out_entering_flux,
  output logic [31:0] out_exit_flux,
  output logic        out_ray_end,
  output logic        out_was_cut
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_MUL  = 3'd1;
  localparam logic [2:0] B_CHK  = 3'd2;
  localparam logic [2:0] B_DIV  = 3'd3;
  localparam logic [2:0] B_OUT  = 3'd4;

  logic [2:0]  state_r, state_nxt;
  rmp_entry_t  cur_r;
  logic [63:0] prod_r;
  logic [31:0] rem_r, quo_r, rate_r;
  logic [4:0]  cnt_r;
  logic        out_valid_r;
  logic        load_out;

  logic [32:0] trial, trial_sub;
  logic        ge;

  assign trial     = {rem_r, quo_r[31]};
  assign trial_sub = trial - {1'b0, cur_r.density};
  assign ge        = (trial >= {1'b0, cur_r.density});

  assign q_pop    = (state_r == B_IDLE) && !q_empty;
  assign load_out = (state_r == B_OUT) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: if (!q_empty) state_nxt = B_MUL;
      B_MUL:  state_nxt = B_CHK;
      B_CHK: begin
        if (cur_r.density == '0 || prod_r[63:32] >= cur_r.density) state_nxt = B_OUT;
        else state_nxt = B_DIV;
      end
      B_DIV:  if (cnt_r == 5'd31) state_nxt = B_OUT;
      B_OUT:  if (load_out) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: if (!q_empty) cur_r <= q_head;
      B_MUL:  prod_r <= 64'(cur_r.absorbed) * 64'(rate_scale);
      B_CHK: begin
        // quotient of 2^32 or more saturates; zero density gives no rate
        rate_r <= (cur_r.density == '0) ? 32'd0 : 32'hFFFF_FFFF;
        rem_r  <= prod_r[63:32];
        quo_r  <= prod_r[31:0];
        cnt_r  <= '0;
      end
      B_DIV: begin
        rem_r  <= ge ? trial_sub[31:0] : trial[31:0];
        quo_r  <= {quo_r[30:0], ge};
        rate_r <= {quo_r[30:0], ge};
        cnt_r  <= cnt_r + 5'd1;
      end
      default: ;
    endcase
    if (load_out) begin
      out_rate_increment <= rate_r;
      out_entering_flux  <= cur_r.entering;
      out_exit_flux      <= cur_r.exit_flux;
      out_ray_end        <= cur_r.last;
      out_was_cut        <= cur_r.cut;
    end
  end

endmodule

[rtl/ray_march_photoionization_unit.sv]
// Ray-march photoionisation unit. The front end takes one cell at a time (in_stall while busy)
// and runs tau, series, eight squarings, flux update and cut test on a shared multiplier; the
// back end takes entries from the queue for a bit-serial divide. Cells past the cut skip the
// march and zero-density or saturating cells skip the divide. Synchronous active-low reset clears
// control state and the running flux, and returns the registers to their reset values.
module ray_march_photoionization_unit import rmp_pkg::*; #(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_density,
  input  logic        in_first_in_ray,
  input  logic        in_last_in_ray,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_rate_increment,
  output logic [31:0] out_entering_flux,
  output logic [31:0] out_exit_flux,
  output logic        out_ray_end,
  output logic        out_was_cut
);

  rmp_cfg_t   cfg_r;
  rmp_entry_t push_data, head;
  logic       push, pop, full, empty;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{initial_flux: INITIAL_FLUX_RST, absorb_scale: ABSORB_SCALE_RST,
                 rate_scale: RATE_SCALE_RST, cutoff_fraction: CUTOFF_FRACTION_RST};
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_INITIAL_FLUX:    cfg_r.initial_flux    <= pwdata;
        REG_ABSORB_SCALE:    cfg_r.absorb_scale    <= pwdata;
        REG_RATE_SCALE:      cfg_r.rate_scale      <= pwdata;
        REG_CUTOFF_FRACTION: cfg_r.cutoff_fraction <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_INITIAL_FLUX:    prdata = cfg_r.initial_flux;
      REG_ABSORB_SCALE:    prdata = cfg_r.absorb_scale;
      REG_RATE_SCALE:      prdata = cfg_r.rate_scale;
      REG_CUTOFF_FRACTION: prdata = {16'd0, cfg_r.cutoff_fraction};
      default:             prdata = '0;
    endcase
  end

  rmp_front u_front (
    .clk, .rst_n, .cfg(cfg_r),
    .in_valid, .in_stall, .in_density, .in_first_in_ray, .in_last_in_ray,
    .q_full(full), .q_push(push), .q_data(push_data)
  );

  rmp_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk, .rst_n, .push, .push_data, .full, .pop, .head, .empty
  );

  rmp_back u_back (
    .clk, .rst_n, .rate_scale(cfg_r.rate_scale),
    .q_empty(empty), .q_head(head), .q_pop(pop),
    .out_valid, .out_stall, .out_rate_increment, .out_entering_flux,
    .out_exit_flux, .out_ray_end, .out_was_cut
  );

endmodule

[rtl/rmp_checker.sv]
// Port-level checks for the ray-march photoionisation unit, bound to the top level.
// Depends only on the top-level ports.
module rmp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_rate_increment,
  input logic [31:0] out_exit_flux,
  input logic        out_ray_end,
  input logic        out_was_cut
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rate_increment))
    else $error("stalled result changed");

  a_exit_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ray_end |-> out_exit_flux == 32'd0)
    else $error("exit flux on a cell that is not last");

  a_exit_not_cut: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_exit_flux != 32'd0 |-> !out_was_cut)
    else $error("exit flux reported on a cut ray");

  // one cell at a time in the front end
  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("front took a second cell while busy");

endmodule

bind ray_march_photoionization_unit rmp_checker u_rmp_checker (.*);

[test/testbench.sv]
// Self-checking bench for ray_march_photoionization_unit: a cell-by-cell flux march
// predictor, valid/stall drivers with random idling and an APB-style register writer.
// Depends on rmp_pkg and the unit's RTL only.
module testbench;
  import rmp_pkg::*;

  typedef struct packed {
    logic [31:0] rate_increment;
    logic [31:0] entering_flux;
    logic [31:0] exit_flux;
    logic        ray_end;
    logic        was_cut;
  } cell_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_density = '0;
  logic        in_first_in_ray = 1'b0, in_last_in_ray = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_rate_increment, out_entering_flux, out_exit_flux;
  logic        out_ray_end, out_was_cut;

  ray_march_photoionization_unit dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state and register shadow
  rmp_cfg_t     shadow_cfg;
  logic [31:0]  march_flux;
  logic         march_cut;
  cell_result_t pending_cells[$];

  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  int quiet_cycles = 0;

  function automatic logic [16:0] exp_neg(logic [47:0] tau);
    logic [63:0] y, t2, t3, t4, s;
    if (tau >= TAU_LIMIT) return 17'd0;
    if (tau == 0) return Q16_ONE;
    y  = 64'(tau) << 8;
    t2 = ((y * y) >> 32) / 2;
    t3 = ((t2 * y) >> 32) / 3;
    t4 = ((t3 * y) >> 32) / 4;
    s  = (64'd1 << 32) - y + t2 - t3 + t4;
    for (int i = 0; i < 8; i++) s = (s * s + (64'd1 << 31)) >> 32;
    return 17'((s + (64'd1 << 15)) >> 16);
  endfunction

  function automatic cell_result_t march_cell(logic [31:0] density, logic first, logic last);
    cell_result_t r;
    logic [63:0] flux, tau, absorbed, q, nflux;
    logic [16:0] e;
    r = '0;
    if (first) begin
      march_flux = shadow_cfg.initial_flux;
      march_cut  = 1'b0;
    end
    if (!march_cut) begin
      flux     = 64'(march_flux);
      tau      = (64'(density) * 64'(shadow_cfg.absorb_scale)) >> 16;
      e        = exp_neg(tau[47:0]);
      absorbed = (flux * 64'(Q16_ONE - e)) >> 16;
      r.entering_flux = march_flux;
      if (density != 0) begin
        q = (absorbed * 64'(shadow_cfg.rate_scale)) / 64'(density);
        r.rate_increment = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
      end
      nflux = (flux * 64'(e) + (64'd1 << 15)) >> 16;
      march_flux = nflux[31:0];
      if ((nflux << 16) < 64'(shadow_cfg.cutoff_fraction) * 64'(shadow_cfg.initial_flux))
        march_cut = 1'b1;
      if (last && !march_cut) r.exit_flux = nflux[31:0];
    end
    r.ray_end = last;
    r.was_cut = march_cut;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    errors++;
  endtask

  // receiver stall and result checking; outputs are stable between edges, so sample at negedge
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(negedge clk) begin
    cell_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_cells.size() == 0) begin
        report_mismatch("unexpected result", out_rate_increment, 32'd0);
      end else begin
        want = pending_cells.pop_front();
        if (out_rate_increment !== want.rate_increment)
          report_mismatch("rate_increment", out_rate_increment, want.rate_increment);
        if (out_entering_flux !== want.entering_flux)
          report_mismatch("entering_flux", out_entering_flux, want.entering_flux);
        if (out_exit_flux !== want.exit_flux)
          report_mismatch("exit_flux", out_exit_flux, want.exit_flux);
        if (out_ray_end !== want.ray_end)
          report_mismatch("ray_end", 32'(out_ray_end), 32'(want.ray_end));
        if (out_was_cut !== want.was_cut)
          report_mismatch("was_cut", 32'(out_was_cut), 32'(want.was_cut));
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= 20000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // called at a rising edge; returns at the edge of the transfer
  task automatic send_cell(logic [31:0] density, logic first, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_density      <= density;
    in_first_in_ray <= first;
    in_last_in_ray  <= last;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    pending_cells.push_back(march_cell(density, first, last));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_INITIAL_FLUX:    shadow_cfg.initial_flux    = value;
      REG_ABSORB_SCALE:    shadow_cfg.absorb_scale    = value;
      REG_RATE_SCALE:      shadow_cfg.rate_scale      = value;
      REG_CUTOFF_FRACTION: shadow_cfg.cutoff_fraction = value[15:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [31:0] flux0, logic [31:0] absorb, logic [31:0] rscale,
                           logic [15:0] cutoff);
    write_reg(REG_INITIAL_FLUX, flux0);
    write_reg(REG_ABSORB_SCALE, absorb);
    write_reg(REG_RATE_SCALE, rscale);
    write_reg(REG_CUTOFF_FRACTION, 32'(cutoff));
  endtask

  function automatic logic [31:0] pick_density();
    case ($urandom_range(5))
      0:       return $urandom();
      1:       return 32'd0;
      2:       return $urandom_range(32'h0003_0000);
      3:       return $urandom_range(32'h0000_4000);
      default: return $urandom_range(32'h0001_0000);
    endcase
  endfunction

  task automatic send_rays(int cells);
    int len;
    while (cells > 0) begin
      if ($urandom_range(9) == 0) begin
        // noise: unmarked or stray marks
        send_cell($urandom(), 1'($urandom()), 1'($urandom()));
        cells--;
      end else begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
          send_cell(pick_density(), i == 0, i == len - 1);
        cells -= len;
      end
    end
  endtask

  task automatic test_reset_values;
    // march before any first mark starts from zero flux
    send_cell(32'h0001_0000, 1'b0, 1'b0);
    send_cell(32'h0000_8000, 1'b1, 1'b0);
    send_cell(32'd0, 1'b0, 1'b0);
    send_cell(32'h0000_0001, 1'b0, 1'b1);
    send_cell(32'h0000_4000, 1'b0, 1'b0);
    send_cell(32'h0002_0000, 1'b1, 1'b1);
    drain();
  endtask

  task automatic test_extremes;
    write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_cell(32'hFFFF_FFFF, 1'b1, 1'b0);
    send_cell(32'd0, 1'b0, 1'b1);
    send_cell(32'd1, 1'b1, 1'b1);
    drain();
    write_all(32'hFFFF_FFFF, 32'h0000_0100, 32'hFFFF_FFFF, 16'd0);
    send_cell(32'h0000_0001, 1'b1, 1'b0);
    send_cell(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_cell(32'h0000_1000, 1'b0, 1'b1);
    drain();
    write_all(32'd0, 32'h0001_0000, 32'd0, 16'h8000);
    send_cell(32'h0000_8000, 1'b1, 1'b0);
    send_cell(32'h0001_0000, 1'b0, 1'b1);
    drain();
    // cutting cell, then cells past the cut
    write_all(32'h0100_0000, 32'h0001_0000, 32'h0004_0000, 16'h4000);
    send_cell(32'h0000_8000, 1'b1, 1'b0);
    send_cell(32'h0001_0000, 1'b0, 1'b0);
    send_cell(32'h0000_4000, 1'b0, 1'b0);
    send_cell(32'h0000_4000, 1'b0, 1'b1);
    send_cell(32'h0000_2000, 1'b0, 1'b0);
    send_cell(32'h0010_0000, 1'b1, 1'b1);
    drain();
  endtask

  task automatic test_random_phase(int ipct, int spct, int cells);
    send_idle_pct  = ipct;
    recv_stall_pct = spct;
    write_all($urandom(), $urandom_range(32'h0004_0000), $urandom(), 16'($urandom()));
    send_rays(cells);
    drain();
  endtask

  task automatic test_backpressure;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    send_rays(24);
    drain();
  endtask

  initial begin
    shadow_cfg = '{INITIAL_FLUX_RST, ABSORB_SCALE_RST, RATE_SCALE_RST, CUTOFF_FRACTION_RST};
    march_flux = '0;
    march_cut  = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_extremes();
    test_random_phase(0, 0, 300);
    test_random_phase(82, 0, 300);
    test_random_phase(0, 82, 300);
    test_random_phase(32, 32, 300);
    test_backpressure();
    repeat (100) @(posedge clk);
    if (errors == 0 && pending_cells.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
